// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the message ring buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define MRB_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("message ring buffer check failed");

// A condition that must hold in the cycle after the antecedent.
`define MRB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("message ring buffer check failed");

`endif

// ===== rtl/mrb_pkg.sv =====
// Types and constants shared by the message ring buffer modules.
`default_nettype none

package mrb_pkg;

  localparam int LEN_W = 11;
  localparam int BYTE_W = 8;
  localparam int FREE_W = 13;
  localparam logic [LEN_W-1:0] CNT_SAT = 11'd2047;

  typedef enum logic [1:0] {
    REQ_HEADER = 2'd0,
    REQ_BODY   = 2'd1,
    REQ_POP    = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ERROR = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_HDR_WR   = 5'b00010,
    S_HDR_RD   = 5'b00100,
    S_POP_RD   = 5'b01000,
    S_POP_WAIT = 5'b10000
  } state_t;

  // Verdict on a header beat, before any state changes.
  typedef struct packed {
    logic len_err;
    logic no_room;
  } admit_t;

endpackage

`default_nettype wire

// ===== rtl/message_ring_buffer.sv =====
// Top level of the variable-length message ring buffer: sequencer and state.
//
//   channel   | handshake               | fields
//   ----------+-------------------------+------------------------------------------
//   request   | start / busy            | req_type, msg_length, data_byte
//   result    | done (one-cycle strobe) | status, out_byte, out_last, out_length,
//             |                         | msg_count, free_bytes
//   config    | cfg_we                  | cfg_wdata (reserve_bytes)
//
// A body push writes its byte as it is taken; a body pop sets the read address, then
// returns the read data from S_POP_WAIT. A header push writes HEADER_BYTES bytes, a
// byte a cycle through the single write port (S_HDR_WR); the first pop of a message
// reads the header a byte a cycle through the single read port (S_HDR_RD), then passes
// S_POP_RD and S_POP_WAIT. Errors, full and empty answers come straight from idle. The
// result beat follows the last cycle of its item; the next request may be taken in that
// same cycle. Reset is synchronous; the store needs no clearing, since only written bytes
// are ever read. The receiver cannot stall the result.
`default_nettype none

module message_ring_buffer import mrb_pkg::*; #(
  parameter int STORE_BYTES = 4096,
  parameter int HEADER_BYTES = 4,
  parameter int MAX_MESSAGE_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type,
  input  logic [LEN_W-1:0]  msg_length,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  output logic              done,
  output logic [1:0]        status,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  output logic [LEN_W-1:0]  out_length,
  output logic [LEN_W-1:0]  msg_count,
  output logic [FREE_W-1:0] free_bytes
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = $clog2(STORE_BYTES + 1);

  state_t            state;
  logic [AW-1:0]     rd_ptr;
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr_next;
  logic [AW-1:0]     wr_ptr_next;
  logic [CW-1:0]     used;
  logic [CW-1:0]     stored;
  logic [LEN_W-1:0]  push_left;
  logic [LEN_W-1:0]  pop_left;
  logic [LEN_W-1:0]  pop_len;
  logic [LEN_W-1:0]  pend_len;
  logic [BYTE_W-1:0] reserve;
  logic [1:0]        byte_idx;
  logic              idx_last;
  logic              new_msg;
  logic              cap_valid;
  logic [1:0]        cap_idx;
  logic [15:0]       hdr_acc;
  logic              accept;
  admit_t            verdict;

  logic              mem_we;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [BYTE_W-1:0] mem_rdata;
  logic [BYTE_W-1:0] hdr_byte;

  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  cur_left_next;

  mrb_admit #(
    .STORE_BYTES       (STORE_BYTES),
    .HEADER_BYTES      (HEADER_BYTES),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
    .CW                (CW)
  ) u_admit (
    .msg_length (msg_length),
    .reserve    (reserve),
    .used       (used),
    .verdict    (verdict)
  );

  mrb_ram #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ptr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_ptr),
    .rdata (mem_rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    rd_ptr_next = (rd_ptr == AW'(STORE_BYTES - 1)) ? '0 : rd_ptr + 1'b1;
    wr_ptr_next = (wr_ptr == AW'(STORE_BYTES - 1)) ? '0 : wr_ptr + 1'b1;
    idx_last    = (byte_idx == 2'(HEADER_BYTES - 1));
    hdr_byte    = BYTE_W'(32'(pend_len) >> {byte_idx, 3'b000});
    cur_len       = new_msg ? hdr_acc[LEN_W-1:0] : pop_len;
    cur_left_next = (new_msg ? hdr_acc[LEN_W-1:0] : pop_left) - 1'b1;
  end

  // Memory ports: header bytes in S_HDR_WR, body bytes from a push beat, reads for pops.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = data_byte;
    mem_re    = 1'b0;
    case (state)
      S_IDLE: begin
        mem_we = accept && (req_type == REQ_BODY) && (push_left != '0);
        mem_re = accept && (req_type == REQ_POP) && (pop_left != '0);
      end
      S_HDR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = hdr_byte;
      end
      S_HDR_RD, S_POP_RD: begin
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Header bytes come back in the cycle after their read; only the low two matter.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      hdr_acc <= '0;
    end else if (cap_valid) begin
      case (cap_idx)
        2'd0: hdr_acc[7:0] <= mem_rdata;
        2'd1: hdr_acc[15:8] <= mem_rdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      used      <= '0;
      stored    <= '0;
      push_left <= '0;
      pop_left  <= '0;
      pop_len   <= '0;
      reserve   <= 8'd1;
      done      <= 1'b0;
      cap_valid <= 1'b0;
    end else begin
      done      <= 1'b0;
      cap_valid <= 1'b0;
      if (cfg_we) begin
        reserve <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            out_byte   <= '0;
            out_last   <= 1'b0;
            out_length <= '0;
            status     <= ST_OK;
            case (req_type)
              REQ_HEADER: begin
                if ((push_left != '0) || verdict.len_err) begin
                  status <= ST_ERROR;
                  done   <= 1'b1;
                end else if (verdict.no_room) begin
                  status <= ST_FULL;
                  done   <= 1'b1;
                end else begin
                  pend_len <= msg_length;
                  byte_idx <= '0;
                  state    <= S_HDR_WR;
                end
              end
              REQ_BODY: begin
                done <= 1'b1;
                if (push_left == '0) begin
                  status <= ST_ERROR;
                end else begin
                  wr_ptr    <= wr_ptr_next;
                  used      <= used + 1'b1;
                  push_left <= push_left - 1'b1;
                  if (push_left == LEN_W'(1)) begin
                    stored <= stored + 1'b1;
                  end
                end
              end
              REQ_POP: begin
                if ((pop_left == '0) && (stored == '0)) begin
                  status <= ST_EMPTY;
                  done   <= 1'b1;
                end else if (pop_left == '0) begin
                  new_msg  <= 1'b1;
                  byte_idx <= '0;
                  state    <= S_HDR_RD;
                end else begin
                  new_msg <= 1'b0;
                  rd_ptr  <= rd_ptr_next;
                  if (used != '0) begin
                    used <= used - 1'b1;
                  end
                  state <= S_POP_WAIT;
                end
              end
              default: begin
                status <= ST_ERROR;
                done   <= 1'b1;
              end
            endcase
          end
        end
        S_HDR_WR: begin
          wr_ptr   <= wr_ptr_next;
          used     <= used + 1'b1;
          byte_idx <= byte_idx + 1'b1;
          if (idx_last) begin
            push_left <= pend_len;
            done      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_HDR_RD: begin
          rd_ptr    <= rd_ptr_next;
          if (used != '0) begin
            used <= used - 1'b1;
          end
          cap_valid <= 1'b1;
          cap_idx   <= byte_idx;
          byte_idx  <= byte_idx + 1'b1;
          if (idx_last) begin
            state <= S_POP_RD;
          end
        end
        S_POP_RD: begin
          rd_ptr <= rd_ptr_next;
          if (used != '0) begin
            used <= used - 1'b1;
          end
          state <= S_POP_WAIT;
        end
        S_POP_WAIT: begin
          pop_len    <= cur_len;
          pop_left   <= cur_left_next;
          out_byte   <= mem_rdata;
          out_length <= cur_len;
          out_last   <= (cur_left_next == '0);
          if ((cur_left_next == '0) && (stored != '0)) begin
            stored <= stored - 1'b1;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The counters already hold the state after the item during the result beat.
  assign msg_count  = (32'(stored) > 32'(CNT_SAT)) ? CNT_SAT : LEN_W'(stored);
  assign free_bytes = FREE_W'(CW'(STORE_BYTES) - used);

endmodule

`default_nettype wire

// ===== rtl/mrb_ram.sv =====
// Byte store of the ring: one write port, one read port, registered read data.
`default_nettype none

module mrb_ram import mrb_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mrb_admit.sv =====
// Admission check for a header beat: length limits and room in the store.
`default_nettype none

module mrb_admit import mrb_pkg::*; #(
  parameter int STORE_BYTES = 4096,
  parameter int HEADER_BYTES = 4,
  parameter int MAX_MESSAGE_BYTES = 1024,
  parameter int CW = 13
) (
  input  logic [LEN_W-1:0]  msg_length,
  input  logic [BYTE_W-1:0] reserve,
  input  logic [CW-1:0]     used,
  output admit_t            verdict
);

  localparam int SW = ((CW > 12) ? CW : 12) + 1;
  localparam int HDR_BITS = 8 * HEADER_BYTES;

  logic [SW-1:0] free_w;
  logic [SW-1:0] rsv_w;
  logic [SW-1:0] need_w;
  logic          too_wide;

  always_comb begin
    free_w = SW'(STORE_BYTES) - SW'(used);
    rsv_w  = SW'(reserve);
    need_w = SW'(HEADER_BYTES) + SW'(msg_length);
    // The length must also fit in the header's bytes.
    too_wide = (HDR_BITS < LEN_W) && ((32'(msg_length) >> HDR_BITS) != 32'd0);
    verdict.len_err = (msg_length == '0) ||
                      (32'(msg_length) > 32'(MAX_MESSAGE_BYTES)) || too_wide;
    verdict.no_room = (rsv_w >= free_w) || (need_w > (free_w - rsv_w));
  end

endmodule

`default_nettype wire

// ===== rtl/mrb_checker.sv =====
// Port-level checks on the message ring buffer, bound to its top level.
`default_nettype none

`include "assert_macros.svh"

module mrb_checker import mrb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        req_type,
  input  logic              done,
  input  logic [1:0]        status,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic              out_last,
  input  logic [LEN_W-1:0]  out_length,
  input  logic [LEN_W-1:0]  msg_count
);

  // A result beat always leaves the block ready for the next request.
  `MRB_ASSERT_ALWAYS(a_done_idle, clk, rst, !done || !busy)

  // A body push is answered in the very next cycle.
  `MRB_ASSERT_NEXT(a_body_one_cycle, clk, rst, start && !busy && (req_type == REQ_BODY), done)

  // An empty answer means no complete message is stored.
  `MRB_ASSERT_ALWAYS(a_empty_count, clk, rst, !(done && (status == ST_EMPTY)) || (msg_count == '0))

  // Only a successful pop carries a byte, a last mark or a length.
  `MRB_ASSERT_ALWAYS(a_fail_quiet, clk, rst, !(done && (status != ST_OK)) || ((out_byte == '0) && !out_last && (out_length == '0)))

  // A last mark always comes with a nonzero message length.
  `MRB_ASSERT_ALWAYS(a_last_len, clk, rst, !(done && out_last) || (out_length != '0))

endmodule

bind message_ring_buffer mrb_checker u_mrb_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .req_type   (req_type),
  .done       (done),
  .status     (status),
  .out_byte   (out_byte),
  .out_last   (out_last),
  .out_length (out_length),
  .msg_count  (msg_count)
);

`default_nettype wire
